### design/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the scan range segmenter: field widths,
// register indexes, the cluster record and the back-end state encoding.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned RANGE_BITS  = 16;

  // Field widths
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned GAP_W   = 12;
  localparam int unsigned SUM_W   = RANGE_W + IDX_W;   // 4096 samples of 16 bits

  // Largest number of samples in one cluster
  localparam logic [COUNT_W-1:0] CLUSTER_CAP = 13'd4096;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT      = 4'd1;
  localparam logic [RANGE_W-1:0]   JUMP_RESET = 16'd100;
  localparam logic [GAP_W-1:0]     GAP_RESET  = 12'd5;

  // Record queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Mean divider: quotient bits retired per cycle and cycles per division
  localparam int unsigned DIV_RADIX = 4;
  localparam int unsigned DIV_STEPS = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // One closed cluster, before the mean is taken
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   last;
    logic               done;
    logic               last_of_run;
  } rec_t;

  // Records written by the front end in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec_a;
    rec_t       rec_b;
  } push_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic room2;     // space for two records
    logic nonempty;
  } q_status_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_WAIT
  } back_state_e;

endpackage

### design/scan_range_segmenter.sv
// ----------------------------------------------------------------------------
// scan_range_segmenter
// Jump-distance segmentation of one lidar scan into clusters with mean
// range, sample count and first and last index.
// ----------------------------------------------------------------------------
// The front end takes one sample per cycle as long as the record queue
// (four entries) has room for two records; a sample closes at most one
// cluster and flushes at most one at scan end. For each reported cluster
// the back end first takes the record, then runs the mean divider, which
// retires four quotient bits per cycle over the 28-bit range sum. It takes
// the next record only once the result has gone to the output register; a
// finished cluster waits in the output register while the next is divided.
// Configuration registers: index 0 jump threshold (mm, reset 100), index 1
// gap limit (samples, reset 5); other indexes are ignored. Write them only
// while no sample is in flight.
// ----------------------------------------------------------------------------
module scan_range_segmenter #(
  parameter int unsigned MaxSamples = scs_pkg::MAX_SAMPLES,
  parameter int unsigned RangeBits  = scs_pkg::RANGE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [scs_pkg::RANGE_W-1:0]    range_mm_i,
  input  logic                           range_valid_i,
  input  logic                           scan_end_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [scs_pkg::RANGE_W-1:0]    mean_range_o,
  output logic [scs_pkg::COUNT_W-1:0]    sample_count_o,
  output logic [scs_pkg::IDX_W-1:0]      first_index_o,
  output logic [scs_pkg::IDX_W-1:0]      final_index_o,
  output logic                           scan_done_o,
  output logic                           last_of_run_o
);
  import scs_pkg::*;

  push_t     q_push;
  q_status_t q_status;
  rec_t      q_head;
  logic      q_pop;

  scs_front #(
    .MaxSamples (MaxSamples),
    .RangeBits  (RangeBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .range_mm_i    (range_mm_i),
    .range_valid_i (range_valid_i),
    .scan_end_i    (scan_end_i),
    .q_status_i    (q_status),
    .q_push_o      (q_push)
  );

  scs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_push_i   (q_push),
    .q_pop_i    (q_pop),
    .q_head_o   (q_head),
    .q_status_o (q_status)
  );

  scs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_head_i       (q_head),
    .q_status_i     (q_status),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .mean_range_o   (mean_range_o),
    .sample_count_o (sample_count_o),
    .first_index_o  (first_index_o),
    .final_index_o  (final_index_o),
    .scan_done_o    (scan_done_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

### design/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front
// Sample classifier: holds the configuration and the open cluster, decides
// per sample whether it joins, closes or flushes, and writes records.
// ----------------------------------------------------------------------------
module scs_front #(
  parameter int unsigned MaxSamples = scs_pkg::MAX_SAMPLES,
  parameter int unsigned RangeBits  = scs_pkg::RANGE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [scs_pkg::RANGE_W-1:0]      range_mm_i,
  input  logic                             range_valid_i,
  input  logic                             scan_end_i,
  input  scs_pkg::q_status_t               q_status_i,
  output scs_pkg::push_t                   q_push_o
);
  import scs_pkg::*;

  localparam int unsigned IW = $clog2(MaxSamples);
  localparam int unsigned RW = (RangeBits < RANGE_W) ? RangeBits : RANGE_W;
  localparam int unsigned DW = (IW + 1 > GAP_W) ? IW + 1 : GAP_W;
  localparam logic [RANGE_W-1:0] RangeMask = RANGE_W'((64'd1 << RW) - 64'd1);

  logic [RANGE_W-1:0] jump_q, jump_d;
  logic [GAP_W-1:0]   gap_q, gap_d;
  logic [SUM_W-1:0]   sum_q, sum_d, v_sum;
  logic [COUNT_W-1:0] size_q, size_d, v_size;
  logic [RANGE_W-1:0] prev_q, prev_d, v_prev;
  logic [IW-1:0]      pvi_q, pvi_d, v_pvi;
  logic [IW-1:0]      si_q, si_d;
  logic [IW-1:0]      cs_q, cs_d, v_cs;
  logic               open_q, open_d, v_open;

  logic               accept;
  logic [RANGE_W-1:0] r, diff;
  logic [IW:0]        idx_dist, si_inc;
  logic               joins, close_rec;
  logic [IW+IDX_W-1:0] cs_ext, pvi_ext, v_cs_ext, v_pvi_ext;
  rec_t               rec_close, rec_flush;

  assign cfg_ready = 1'b1;
  assign full      = !q_status_i.room2;
  assign accept    = push && !full;

  // Configuration writes
  always_comb begin
    jump_d = jump_q;
    gap_d  = gap_q;
    if (cfg_valid) begin
      unique case (cfg_index_i)
        CFG_JUMP_THRESHOLD: jump_d = cfg_data_i[RANGE_W-1:0];
        CFG_GAP_LIMIT:      gap_d  = cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Join test against the previous valid sample
  always_comb begin
    r    = range_mm_i & RangeMask;
    diff = (r >= prev_q) ? r - prev_q : prev_q - r;
    if (si_q >= pvi_q) begin
      idx_dist = {1'b0, si_q} - {1'b0, pvi_q};
    end else begin
      idx_dist = {1'b0, si_q} + (IW+1)'(MaxSamples) - {1'b0, pvi_q};
    end
    joins = open_q && (diff <= jump_q) && (DW'(idx_dist) <= DW'(gap_q)) &&
            (size_q < CLUSTER_CAP);
    close_rec = range_valid_i && open_q && !joins;
  end

  // Cluster state after the sample, before any end-of-scan clear
  always_comb begin
    v_sum  = sum_q;
    v_size = size_q;
    v_prev = prev_q;
    v_pvi  = pvi_q;
    v_cs   = cs_q;
    v_open = open_q;
    if (range_valid_i) begin
      if (joins) begin
        v_sum  = sum_q + SUM_W'(r);
        v_size = size_q + COUNT_W'(1);
      end else begin
        v_sum  = SUM_W'(r);
        v_size = COUNT_W'(1);
        v_cs   = si_q;
        v_open = 1'b1;
      end
      v_prev = r;
      v_pvi  = si_q;
    end
  end

  // Records: a close from the old cluster, a flush from the new state
  always_comb begin
    cs_ext    = {{IDX_W{1'b0}}, cs_q};
    pvi_ext   = {{IDX_W{1'b0}}, pvi_q};
    v_cs_ext  = {{IDX_W{1'b0}}, v_cs};
    v_pvi_ext = {{IDX_W{1'b0}}, v_pvi};

    rec_close.sum         = sum_q;
    rec_close.count       = size_q;
    rec_close.first       = cs_ext[IDX_W-1:0];
    rec_close.last        = pvi_ext[IDX_W-1:0];
    rec_close.done        = 1'b0;
    rec_close.last_of_run = !(scan_end_i && v_open);

    rec_flush.sum         = v_sum;
    rec_flush.count       = v_size;
    rec_flush.first       = v_cs_ext[IDX_W-1:0];
    rec_flush.last        = v_pvi_ext[IDX_W-1:0];
    rec_flush.done        = 1'b1;
    rec_flush.last_of_run = 1'b1;

    q_push_o.rec_a = close_rec ? rec_close : rec_flush;
    q_push_o.rec_b = rec_flush;
    q_push_o.cnt   = 2'd0;
    if (accept) begin
      q_push_o.cnt = {1'b0, close_rec} + {1'b0, scan_end_i && v_open};
    end
  end

  // Next cluster state
  always_comb begin
    si_inc = {1'b0, si_q} + (IW+1)'(1);
    sum_d  = sum_q;
    size_d = size_q;
    prev_d = prev_q;
    pvi_d  = pvi_q;
    cs_d   = cs_q;
    open_d = open_q;
    si_d   = si_q;
    if (accept) begin
      if (scan_end_i) begin
        sum_d  = '0;
        size_d = '0;
        prev_d = '0;
        pvi_d  = '0;
        cs_d   = '0;
        open_d = 1'b0;
        si_d   = '0;
      end else begin
        sum_d  = v_sum;
        size_d = v_size;
        prev_d = v_prev;
        pvi_d  = v_pvi;
        cs_d   = v_cs;
        open_d = v_open;
        si_d   = (si_inc >= (IW+1)'(MaxSamples)) ? '0 : si_inc[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q <= JUMP_RESET;
      gap_q  <= GAP_RESET;
      sum_q  <= '0;
      size_q <= '0;
      prev_q <= '0;
      pvi_q  <= '0;
      cs_q   <= '0;
      open_q <= 1'b0;
      si_q   <= '0;
    end else begin
      jump_q <= jump_d;
      gap_q  <= gap_d;
      sum_q  <= sum_d;
      size_q <= size_d;
      prev_q <= prev_d;
      pvi_q  <= pvi_d;
      cs_q   <= cs_d;
      open_q <= open_d;
      si_q   <= si_d;
    end
  end

endmodule

### design/scs_queue.sv
// ----------------------------------------------------------------------------
// scs_queue
// Short record queue between classifier and divider; takes up to two
// records per cycle and gives one.
// ----------------------------------------------------------------------------
module scs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scs_pkg::push_t     q_push_i,
  input  logic               q_pop_i,
  output scs_pkg::rec_t      q_head_o,
  output scs_pkg::q_status_t q_status_o
);
  import scs_pkg::*;

  rec_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nxt;
  logic [QCNT_W-1:0] count_q, count_d;

  // Pointers and fill level
  always_comb begin
    wptr_nxt = wptr_q + QPTR_W'(1);
    wptr_d   = wptr_q + QPTR_W'(q_push_i.cnt);
    rptr_d   = rptr_q + QPTR_W'(q_pop_i);
    count_d  = count_q + QCNT_W'(q_push_i.cnt) - QCNT_W'(q_pop_i);
  end

  assign q_head_o            = entries_q[rptr_q];
  assign q_status_o.nonempty = (count_q != '0);
  assign q_status_o.room2    = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

  // Storage
  always_ff @(posedge clk_i) begin
    if (q_push_i.cnt != 2'd0) begin
      entries_q[wptr_q] <= q_push_i.rec_a;
    end
    if (q_push_i.cnt == 2'd2) begin
      entries_q[wptr_nxt] <= q_push_i.rec_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

### design/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back
// Cluster finisher: takes a record, divides the range sum by the sample
// count DIV_RADIX quotient bits per cycle, and holds the result for transfer.
// ----------------------------------------------------------------------------
module scs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scs_pkg::rec_t                 q_head_i,
  input  scs_pkg::q_status_t            q_status_i,
  output logic                          q_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [scs_pkg::RANGE_W-1:0]   mean_range_o,
  output logic [scs_pkg::COUNT_W-1:0]   sample_count_o,
  output logic [scs_pkg::IDX_W-1:0]     first_index_o,
  output logic [scs_pkg::IDX_W-1:0]     final_index_o,
  output logic                          scan_done_o,
  output logic                          last_of_run_o
);
  import scs_pkg::*;

  back_state_e        state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d, dvd_step;
  logic [COUNT_W-1:0] rem_q, rem_d, rem_step;
  rec_t               rec_q;
  logic               start, load_out, out_free;
  logic               out_valid_q, out_valid_d;
  logic [DIV_W-1:0]   quot_sel;
  logic [COUNT_W:0]   trial;

  // Quotient bits of one cycle, restoring division
  always_comb begin
    dvd_step = dvd_q;
    rem_step = rem_q;
    trial    = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial    = {rem_step, dvd_step[DIV_W-1]};
      dvd_step = {dvd_step[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, rec_q.count}) begin
        trial       = trial - {1'b0, rec_q.count};
        dvd_step[0] = 1'b1;
      end
      rem_step = trial[COUNT_W-1:0];
    end
  end

  assign out_free = !out_valid_q || pop;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_IDLE: if (q_status_i.nonempty) state_d = BACK_DIV;
      BACK_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = out_free ? BACK_IDLE : BACK_WAIT;
        end
      end
      BACK_WAIT: if (out_free) state_d = BACK_IDLE;
      default:   state_d = BACK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    start    = 1'b0;
    load_out = 1'b0;
    quot_sel = dvd_step;
    unique case (state_q)
      BACK_IDLE: start = q_status_i.nonempty;
      BACK_DIV:  load_out = (step_q == STEP_W'(DIV_STEPS - 1)) && out_free;
      BACK_WAIT: begin
        load_out = out_free;
        quot_sel = dvd_q;
      end
      default: ;
    endcase
  end

  assign q_pop_o = start;

  // Divider datapath
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (start) begin
      dvd_d  = DIV_W'(q_head_i.sum);
      rem_d  = '0;
      step_d = '0;
    end else if (state_q == BACK_DIV) begin
      dvd_d  = dvd_step;
      rem_d  = rem_step;
      step_d = step_q + STEP_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  assign empty = !out_valid_q;

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start) rec_q <= q_head_i;
    if (load_out) begin
      mean_range_o   <= quot_sel[RANGE_W-1:0];
      sample_count_o <= rec_q.count;
      first_index_o  <= rec_q.first;
      final_index_o  <= rec_q.last;
      scan_done_o    <= rec_q.done;
      last_of_run_o  <= rec_q.last_of_run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### test/cluster_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_monitor
// Watches the sample, register and cluster channels of the segmenter. It
// keeps its own copy of the segmentation state and the registers, works out
// the clusters that each accepted sample closes, and checks every cluster
// popped from the block against the oldest one still owed.
// ----------------------------------------------------------------------------
module cluster_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  input  logic                           full,
  input  logic [scs_pkg::RANGE_W-1:0]    range_mm_i,
  input  logic                           range_valid_i,
  input  logic                           scan_end_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [scs_pkg::RANGE_W-1:0]    mean_range_i,
  input  logic [scs_pkg::COUNT_W-1:0]    sample_count_i,
  input  logic [scs_pkg::IDX_W-1:0]      first_index_i,
  input  logic [scs_pkg::IDX_W-1:0]      final_index_i,
  input  logic                           scan_done_i,
  input  logic                           last_of_run_i,
  output int                             mismatch_count_o,
  output int                             clusters_due_o
);
  import scs_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RANGE_W-1:0] mean;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   first_idx;
    logic [IDX_W-1:0]   last_idx;
    logic               scan_done;
    logic               run_end;
  } cluster_t;

  // Register copies
  logic [RANGE_W-1:0] jump_thr;
  logic [GAP_W-1:0]   gap_lim;

  // Segmentation state
  logic [SUM_W-1:0]   sum_acc;
  logic [COUNT_W-1:0] clus_size;
  logic [RANGE_W-1:0] prev_rng;
  logic [IDX_W-1:0]   prev_idx;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   clus_first;
  logic               clus_open;

  cluster_t clusters_due[$];

  // Report of the open cluster, mean truncated
  function automatic cluster_t close_cluster(input logic flushed);
    cluster_t         c;
    logic [SUM_W-1:0] quot;
    quot        = sum_acc / SUM_W'(clus_size);
    c.mean      = quot[RANGE_W-1:0];
    c.count     = clus_size;
    c.first_idx = clus_first;
    c.last_idx  = prev_idx;
    c.scan_done = flushed;
    c.run_end   = 1'b0;
    return c;
  endfunction

  task automatic clear_scan();
    sum_acc    = '0;
    clus_size  = '0;
    prev_rng   = '0;
    prev_idx   = '0;
    clus_first = '0;
    clus_open  = 1'b0;
    cur_idx    = '0;
  endtask

  // One accepted sample: close of the open cluster first, then the end-of-scan flush
  task automatic segment_sample(input logic [RANGE_W-1:0] rng, input logic ok,
                                input logic stop);
    logic [RANGE_W-1:0] diff;
    logic [IDX_W-1:0]   idx_gap;
    logic               joins;
    cluster_t           made [2];
    int                 n;
    n = 0;
    if (ok) begin
      joins = 1'b0;
      if (clus_open) begin
        diff    = (rng >= prev_rng) ? rng - prev_rng : prev_rng - rng;
        // index distance wraps with the 12-bit index
        idx_gap = cur_idx - prev_idx;
        joins   = (diff <= jump_thr) && (idx_gap <= gap_lim) &&
                  (clus_size < CLUSTER_CAP);
      end
      if (joins) begin
        sum_acc   = sum_acc + SUM_W'(rng);
        clus_size = clus_size + COUNT_W'(1);
      end else begin
        if (clus_open) begin
          made[n] = close_cluster(1'b0);
          n++;
        end
        sum_acc    = SUM_W'(rng);
        clus_size  = COUNT_W'(1);
        clus_first = cur_idx;
        clus_open  = 1'b1;
      end
      prev_rng = rng;
      prev_idx = cur_idx;
    end
    if (stop) begin
      if (clus_open) begin
        made[n] = close_cluster(1'b1);
        n++;
      end
      clear_scan();
    end else begin
      cur_idx = cur_idx + IDX_W'(1);
    end
    if (n > 0) made[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) clusters_due = {clusters_due, made[i]};
  endtask

  task automatic note_mismatch(input string what, input cluster_t want, input cluster_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= MAX_REPORTS)
      $display({"%0t: %s: exp mean=%0d cnt=%0d first=%0d final=%0d done=%0b last=%0b,",
                " got mean=%0d cnt=%0d first=%0d final=%0d done=%0b last=%0b"},
               $realtime, what, want.mean, want.count, want.first_idx, want.last_idx,
               want.scan_done, want.run_end, got.mean, got.count, got.first_idx,
               got.last_idx, got.scan_done, got.run_end);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cluster_t want;
    cluster_t got;
    if (!rst_ni) begin
      jump_thr = JUMP_RESET;
      gap_lim  = GAP_RESET;
      clear_scan();
      clusters_due.delete();
      mismatch_count_o = 0;
    end else begin
      // Register transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          CFG_JUMP_THRESHOLD: jump_thr = cfg_data_i[RANGE_W-1:0];
          CFG_GAP_LIMIT:      gap_lim  = cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
      // Cluster transfer
      if (pop && !empty) begin
        got = {mean_range_i, sample_count_i, first_index_i, final_index_i,
               scan_done_i, last_of_run_i};
        if (clusters_due.size() == 0) begin
          note_mismatch("cluster with none owed", '0, got);
        end else begin
          want = clusters_due.pop_front();
          if (got !== want) note_mismatch("cluster mismatch", want, got);
        end
      end
      // Sample transfer
      if (push && !full) segment_sample(range_mm_i, range_valid_i, scan_end_i);
    end
    clusters_due_o = clusters_due.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scan samples and register writes into the segmenter and gives the
// verdict. Directed samples hit the threshold and gap edges and the
// end-of-scan cases, and random scans then run under several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import scs_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_SAMPLES = 90;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_GAP_LIMIT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic [RANGE_W-1:0]    range_mm;
  logic                  range_valid;
  logic                  scan_end;
  logic                  empty;
  logic                  pop;
  logic [RANGE_W-1:0]    mean_range;
  logic [COUNT_W-1:0]    sample_count;
  logic [IDX_W-1:0]      first_index;
  logic [IDX_W-1:0]      final_index;
  logic                  scan_done;
  logic                  last_of_run;

  int mismatches;
  int outstanding;
  int samples_sent = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int cur_jump     = JUMP_RESET;
  int cur_gap      = GAP_RESET;

  // Register settings and idle pattern of each random phase
  logic [CFG_DATA_W-1:0] jump_plan [NUM_PHASES] =
    '{16'd200, 16'd0, 16'hFFFF, 16'd50, 16'd0, 16'd1000, 16'hFFFF, 16'd0};
  logic [CFG_DATA_W-1:0] gap_plan [NUM_PHASES] =
    '{16'd3, 16'd1, 16'hFFFF, 16'hF000, 16'd0, 16'd2, 16'd1, 16'd0};
  bit rand_plan [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 1};
  int tx_plan   [NUM_PHASES] = '{0, 76, 0, 33, 0, 76, 0, 33};
  int rx_plan   [NUM_PHASES] = '{0, 0, 76, 33, 0, 0, 76, 33};

  always #HALF_PERIOD clk_i = ~clk_i;

  scan_range_segmenter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .range_mm_i     (range_mm),
    .range_valid_i  (range_valid),
    .scan_end_i     (scan_end),
    .empty          (empty),
    .pop            (pop),
    .mean_range_o   (mean_range),
    .sample_count_o (sample_count),
    .first_index_o  (first_index),
    .final_index_o  (final_index),
    .scan_done_o    (scan_done),
    .last_of_run_o  (last_of_run)
  );

  cluster_monitor u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .range_mm_i       (range_mm),
    .range_valid_i    (range_valid),
    .scan_end_i       (scan_end),
    .empty            (empty),
    .pop              (pop),
    .mean_range_i     (mean_range),
    .sample_count_i   (sample_count),
    .first_index_i    (first_index),
    .final_index_i    (final_index),
    .scan_done_i      (scan_done),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatches),
    .clusters_due_o   (outstanding)
  );

  // Receiver side: random stalls on the cluster channel
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // One sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic ok,
                             input logic stop);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    range_mm    <= rng;
    range_valid <= ok;
    scan_end    <= stop;
    do @(posedge clk_i); while (full);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every owed cluster has come out, then let the block settle
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A scan of mostly valid samples whose steps sit around the jump threshold,
  // with stretches of skipped samples around the gap limit
  task automatic send_scan(input int len);
    int rng;
    int step;
    int roll;
    int run;
    int k;
    rng = $urandom_range(0, 65535);
    k   = 0;
    while (k < len) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        run = $urandom_range(1, (cur_gap + 2 < 10) ? cur_gap + 2 : 10);
        repeat (run) begin
          if (k < len) begin
            send_sample(16'($urandom), 1'b0, k == len - 1);
            k++;
          end
        end
      end else begin
        if (roll < 70) step = $urandom_range(0, cur_jump);
        else if (roll < 85) step = cur_jump + $urandom_range(0, 1);
        else step = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) == 1) step = -step;
        rng = rng + step;
        if (rng < 0) rng = 0;
        if (rng > 65535) rng = 65535;
        send_sample(16'(rng), 1'b1, k == len - 1);
        k++;
      end
    end
  endtask

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] jump;
    logic [CFG_DATA_W-1:0] gap;
    int                    start;
    rst_ni      = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    push        = 1'b0;
    pop         = 1'b0;
    range_mm    = '0;
    range_valid = 1'b0;
    scan_end    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples under the reset settings (threshold 100, gap 5)
    send_sample(16'hA5A5, 1'b0, 1'b1);   // skipped end with nothing open
    send_sample(16'd1000, 1'b1, 1'b0);   // first valid sample opens a cluster
    send_sample(16'd1100, 1'b1, 1'b0);   // step equal to the threshold joins
    send_sample(16'd1201, 1'b1, 1'b0);   // one over the threshold closes
    repeat (4) send_sample(16'($urandom), 1'b0, 1'b0);
    send_sample(16'd1201, 1'b1, 1'b0);   // distance equal to the gap joins
    repeat (5) send_sample(16'($urandom), 1'b0, 1'b0);
    send_sample(16'd1201, 1'b1, 1'b0);   // distance one over the gap closes
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b1);   // jump close and flush together
    send_sample(16'hFFFF, 1'b1, 1'b1);   // single-sample cluster flushed
    send_sample(16'h0000, 1'b0, 1'b1);
    send_sample(16'h5A5A, 1'b0, 1'b0);
    send_sample(16'h1234, 1'b1, 1'b0);
    send_sample(16'h1234, 1'b0, 1'b1);   // skipped end flushes the open cluster

    // Random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      tx_idle_pct  = tx_plan[ph];
      rx_stall_pct <= rx_plan[ph];
      jump = rand_plan[ph] ? 16'($urandom) : jump_plan[ph];
      gap  = rand_plan[ph] ? 16'($urandom_range(1, 20)) : gap_plan[ph];
      write_reg(CFG_JUMP_THRESHOLD, jump);
      write_reg(CFG_GAP_LIMIT, gap);
      write_reg((ph == 0) ? CFG_UNUSED_LAST
                          : CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                16'($urandom));
      cur_jump = jump;
      cur_gap  = gap[GAP_W-1:0];
      start    = samples_sent;
      while (samples_sent - start < PHASE_SAMPLES) begin
        if ($urandom_range(0, 99) < 12) begin
          // noise: fields fully random
          repeat ($urandom_range(1, 4))
            send_sample(16'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          send_scan($urandom_range(1, 30));
        end
      end
    end

    drain();
    @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
